// File: src/bkh_pkg.sv
// Shared types, constants and the mix round function of the byte key hash.
package bkh_pkg;

  localparam logic [31:0] GoldenRatio = 32'h9e37_79b9;
  localparam int unsigned BlockBytes  = 12;
  localparam int unsigned PosWidth    = 4;
  localparam int unsigned MixRounds   = 9;
  localparam int unsigned StepWidth   = 4;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueueAw     = $clog2(QueueDepth);

  localparam logic [PosWidth-1:0]  LastBlockPos = PosWidth'(BlockBytes - 1);
  localparam logic [StepWidth-1:0] LastStep     = StepWidth'(MixRounds - 1);

  // Three hash words.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  // One unit of work for the back end: a full block, a tail, or both ends.
  typedef struct packed {
    logic [31:0] a_part;
    logic [31:0] b_part;
    logic [31:0] c_part;
    logic [31:0] key_len;
    logic        is_full;
    logic        is_last;
  } job_t;

  // One round of the lookup2 mix; the nine rounds are selected by step.
  function automatic words_t mix_round(words_t w, logic [StepWidth-1:0] step);
    words_t r;
    r = w;
    case (step)
      4'd0:    r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
      4'd1:    r.b = (w.b - w.c - w.a) ^ (w.a << 8);
      4'd2:    r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
      4'd3:    r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
      4'd4:    r.b = (w.b - w.c - w.a) ^ (w.a << 16);
      4'd5:    r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
      4'd6:    r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
      4'd7:    r.b = (w.b - w.c - w.a) ^ (w.a << 10);
      4'd8:    r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

// File: src/bkh_if.sv
// Valid/ready channel interfaces for key bytes in and hash values out.
interface bkh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, key_byte, byte_present, last_byte, input ready);
  modport sink   (input valid, key_byte, byte_present, last_byte, output ready);
endinterface

interface bkh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// File: src/bkh_front.sv
// Front end: gathers key bytes into 12-byte blocks and issues block and tail jobs.
module bkh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  bkh_in_if.sink        key_if_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output bkh_pkg::job_t job_o
);
  import bkh_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [31:0]         len_q, len_d;
  logic [31:0]         a_part_q, a_part_d;
  logic [31:0]         b_part_q, b_part_d;
  logic [31:0]         c_part_q, c_part_d;
  logic [31:0]         a_ins, b_ins, c_ins;
  logic [31:0]         byte_shifted;
  logic                accept;
  logic                present;
  logic                block_done;

  assign key_if_i.ready = !queue_full_i;
  assign accept         = key_if_i.valid && !queue_full_i;
  assign present        = key_if_i.byte_present;

  // Place the byte at its little-endian lane inside the selected word.
  assign byte_shifted = {24'd0, key_if_i.key_byte} << {pos_q[1:0], 3'b000};

  always_comb begin
    a_ins = a_part_q;
    b_ins = b_part_q;
    c_ins = c_part_q;
    if (present) begin
      if (pos_q[3]) begin
        c_ins = c_part_q | byte_shifted;
      end else if (pos_q[2]) begin
        b_ins = b_part_q | byte_shifted;
      end else begin
        a_ins = a_part_q | byte_shifted;
      end
    end
  end

  assign block_done = present && (pos_q == LastBlockPos);

  // A job leaves whenever a block fills or the key ends.
  assign push_o        = accept && (block_done || key_if_i.last_byte);
  assign job_o.a_part  = a_ins;
  assign job_o.b_part  = b_ins;
  assign job_o.c_part  = c_ins;
  assign job_o.key_len = len_q + {31'd0, present};
  assign job_o.is_full = block_done;
  assign job_o.is_last = key_if_i.last_byte;

  // Next gathering state.
  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    a_part_d = a_part_q;
    b_part_d = b_part_q;
    c_part_d = c_part_q;
    if (accept) begin
      if (key_if_i.last_byte || block_done) begin
        a_part_d = '0;
        b_part_d = '0;
        c_part_d = '0;
        pos_d    = '0;
      end else if (present) begin
        a_part_d = a_ins;
        b_part_d = b_ins;
        c_part_d = c_ins;
        pos_d    = pos_q + PosWidth'(1);
      end
      if (key_if_i.last_byte) begin
        len_d = '0;
      end else if (present) begin
        len_d = len_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      a_part_q <= '0;
      b_part_q <= '0;
      c_part_q <= '0;
    end else begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      a_part_q <= a_part_d;
      b_part_q <= b_part_d;
      c_part_q <= c_part_d;
    end
  end

endmodule

// File: src/bkh_queue.sv
// Short job queue between the front and back ends.
module bkh_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bkh_pkg::job_t job_i,
  input  logic          pop_i,
  output bkh_pkg::job_t job_o,
  output logic          full_o,
  output logic          empty_o
);
  import bkh_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q;
  logic [QueueAw-1:0]   rd_ptr_q;
  logic [QueueAw:0]     count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == (QueueAw+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueueAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QueueAw+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QueueAw+1)'(1);
      end
    end
  end

endmodule

// File: src/bkh_back.sv
// Back end: adds jobs to the words, mixes a round a cycle, emits the hash when output is free.
module bkh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  bkh_pkg::job_t job_i,
  output logic          pop_o,
  bkh_out_if.source     hash_if_o
);
  import bkh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_TAIL
  } state_e;

  localparam words_t InitWords = '{a: GoldenRatio, b: GoldenRatio, c: 32'd0};

  state_e               state_q;
  words_t               words_q;
  words_t               round_w;
  logic [StepWidth-1:0] step_q;
  logic [31:0]          len_q;
  logic                 final_pending_q;
  logic                 emit_q;
  logic                 out_valid_q;
  logic [31:0]          hash_q;
  logic                 out_free;
  logic                 emit_now;

  assign round_w  = mix_round(words_q, step_q);
  assign pop_o    = (state_q == S_IDLE) && job_valid_i;
  assign out_free = !out_valid_q || hash_if_o.ready;

  // The last round of a key end goes out as soon as the output register is free.
  assign emit_now = (state_q == S_MIX) && (step_q == LastStep) && !final_pending_q &&
                    emit_q && out_free;

  assign hash_if_o.valid      = out_valid_q;
  assign hash_if_o.hash_value = hash_q;

  // Sequencer, hash words and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      words_q         <= InitWords;
      step_q          <= '0;
      len_q           <= '0;
      final_pending_q <= 1'b0;
      emit_q          <= 1'b0;
      out_valid_q     <= 1'b0;
      hash_q          <= '0;
    end else begin
      if (emit_now) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && hash_if_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            words_q.a       <= words_q.a + job_i.a_part;
            words_q.b       <= words_q.b + job_i.b_part;
            // A full block adds its third word as is; a tail adds it a byte up plus the length.
            if (job_i.is_full) begin
              words_q.c <= words_q.c + job_i.c_part;
            end else begin
              words_q.c <= words_q.c + job_i.key_len + {job_i.c_part[23:0], 8'd0};
            end
            len_q           <= job_i.key_len;
            final_pending_q <= job_i.is_full && job_i.is_last;
            emit_q          <= !job_i.is_full;
            step_q          <= '0;
            state_q         <= S_MIX;
          end
        end
        S_MIX: begin
          if (step_q != LastStep) begin
            words_q <= round_w;
            step_q  <= step_q + StepWidth'(1);
          end else if (final_pending_q) begin
            words_q         <= round_w;
            final_pending_q <= 1'b0;
            state_q         <= S_TAIL;
          end else if (emit_q) begin
            // Hold the last round until the output register is free.
            if (out_free) begin
              hash_q      <= round_w.c;
              words_q     <= InitWords;
              emit_q      <= 1'b0;
              state_q     <= S_IDLE;
            end
          end else begin
            words_q <= round_w;
            state_q <= S_IDLE;
          end
        end
        S_TAIL: begin
          // The key ended on a block boundary: only the length goes in.
          words_q.c <= words_q.c + len_q;
          emit_q    <= 1'b1;
          step_q    <= '0;
          state_q   <= S_MIX;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/byte_key_hash_lookup2_core.sv
// Top level of the streaming lookup2 byte key hash.
//
// Takes one key byte per cycle and returns the 32-bit lookup2 hash after the item
// that ends the key. The front end accepts a byte every cycle as long as the
// four-entry job queue has room. The back end adds the gathered words of each
// job into the hash state, then runs the nine mix rounds, one round a cycle, and
// takes no new job until it is through. A full 12-byte block is one job, so long
// keys stream at one byte per cycle. A key end is one job; when its last byte
// completes a block, the length is then added alone and the mix runs once more.
// The hash then waits in an output register, so a stalled consumer holds up only
// the next key end. Very short keys are therefore limited by the back end.
module byte_key_hash_lookup2_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bkh_in_if.sink     key_if_i,
  bkh_out_if.source  hash_if_o
);
  import bkh_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;

  // Byte gathering.
  bkh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_if_i     (key_if_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // Decoupling queue.
  bkh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (queue_full),
    .empty_o (queue_empty)
  );

  // Mixing and emission.
  bkh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!queue_empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .hash_if_o   (hash_if_o)
  );

endmodule
